/* hdl/mccd_pkg.sv */
package mccd_pkg;

    localparam int NUM_DENOMS = 5;
    localparam int DENOM_W    = 10;
    localparam int COUNT_W    = 11;
    localparam int PICK_W     = 3;
    localparam int OUT_W      = 10;
    localparam int CFG_IDX_W  = 3;

    // all-ones count marks a sum that cannot be made
    localparam logic [COUNT_W-1:0] UNREACH = '1;

    typedef logic [NUM_DENOMS-1:0][DENOM_W-1:0] denom_arr_t;

    localparam denom_arr_t DENOM_RESET = {10'd31, 10'd15, 10'd7, 10'd3, 10'd1};

    // one table entry: last coin used and fewest coin count
    typedef struct packed {
        logic [PICK_W-1:0]  last;
        logic [COUNT_W-1:0] best;
    } entry_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ZERO,
        ST_FILL,
        ST_LOOK,
        ST_HEAD,
        ST_WREAD,
        ST_WSTEP,
        ST_DONE
    } mccd_state_t;

endpackage

/* hdl/min_coin_change_dp_unit.sv */
// an accepted amount builds the table from sum zero up to that amount, then walks
// back through the last coins; unreachable amounts skip the walk
// one item at a time: a new amount is taken only in the idle state; each sum
// takes five table reads through the single read port plus the write-back
// reset: rst_n asynchronous active low; denominations return to 1,3,7,15,31
// and all handshakes go idle; the table memory is scratch and is not cleared
module min_coin_change_dp_unit import mccd_pkg::*; #(
    parameter int MAX_AMOUNT = 1023
) (
    input  logic                 clk,
    input  logic                 rst_n,
    // input requests
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [15:0]          s_tdata,    // amount[9:0], zero fill
    // result requests
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [63:0]          m_tdata,    // found, total_coins, count_a..count_e, zero fill
    // configuration writes
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [DENOM_W-1:0]   cfg_data
);

    localparam int DEPTH  = MAX_AMOUNT + 1;
    localparam int AW     = (DEPTH > 2) ? $clog2(DEPTH) : 1;
    // wide enough for any sum, denomination or amount limit
    localparam int WIDE_W = 17;
    localparam logic [WIDE_W-1:0] MAX_WIDE = WIDE_W'(MAX_AMOUNT);

    // control state
    mccd_state_t state_reg, state_next;
    denom_arr_t  denom_reg;
    logic        out_valid_reg, out_valid_next;

    // working registers
    logic [AW-1:0]      target_reg, target_next;
    logic [AW-1:0]      s_reg, s_next;           // current sum, then remainder on walk
    logic [2:0]         k_reg, k_next;           // denomination slot inside one sum
    logic [COUNT_W-1:0] best_reg, best_next;
    logic [PICK_W-1:0]  pick_reg, pick_next;
    logic               cand_reg, cand_next;     // read data in flight is a candidate
    logic               found_reg, found_next;
    logic [OUT_W-1:0]   total_reg, total_next;
    logic [NUM_DENOMS-1:0][OUT_W-1:0] count_reg, count_next;
    logic [63:0]        out_data_reg, out_data_next;

    // table port
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    entry_t        wr_entry;
    logic          rd_en;
    logic [AW-1:0] rd_addr;
    entry_t        rd_entry;

    // shared compare unit signals
    logic [DENOM_W-1:0] d_sel;
    logic [WIDE_W-1:0]  s_wide;
    logic [WIDE_W-1:0]  d_wide;
    logic [WIDE_W-1:0]  diff_wide;
    logic               d_fits;
    logic [COUNT_W-1:0] cand_count;
    logic               take;
    logic [COUNT_W-1:0] best_upd;
    logic [PICK_W-1:0]  pick_upd;
    logic [WIDE_W-1:0]  amount_wide;

    function automatic logic [DENOM_W-1:0] select_denom(
        input denom_arr_t         den,
        input logic [PICK_W-1:0]  idx
    );
        logic [DENOM_W-1:0] d;
        case (idx)
            3'd0:    d = den[0];
            3'd1:    d = den[1];
            3'd2:    d = den[2];
            3'd3:    d = den[3];
            3'd4:    d = den[4];
            default: d = '0;
        endcase
        return d;
    endfunction

    mccd_table #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_table (
        .clk      (clk),
        .wr_en    (wr_en),
        .wr_addr  (wr_addr),
        .wr_entry (wr_entry),
        .rd_en    (rd_en),
        .rd_addr  (rd_addr),
        .rd_entry (rd_entry)
    );

    assign s_tready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = out_data_reg;

    assign amount_wide = {{(WIDE_W - 10){1'b0}}, s_tdata[9:0]};

    // denomination for the fill slot or for the walk step
    always_comb
    begin
        if (state_reg == ST_WSTEP)
        begin
            d_sel = select_denom(denom_reg, rd_entry.last);
        end
        else
        begin
            d_sel = select_denom(denom_reg, k_reg);
        end
    end

    assign s_wide    = WIDE_W'(s_reg);
    assign d_wide    = {{(WIDE_W - DENOM_W){1'b0}}, d_sel};
    assign diff_wide = s_wide - d_wide;
    assign d_fits    = (d_sel != '0) && (d_wide <= s_wide);

    // relaxation: previous entry plus one coin against current best
    assign cand_count = rd_entry.best + COUNT_W'(1);
    assign take       = cand_reg && (rd_entry.best != UNREACH) && (cand_count < best_reg);
    assign best_upd   = take ? cand_count : best_reg;
    assign pick_upd   = take ? PICK_W'(k_reg - 3'd1) : pick_reg;

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        target_next    = target_reg;
        s_next         = s_reg;
        k_next         = k_reg;
        best_next      = best_reg;
        pick_next      = pick_reg;
        cand_next      = 1'b0;
        found_next     = found_reg;
        total_next     = total_reg;
        count_next     = count_reg;
        wr_en          = 1'b0;
        wr_addr        = s_reg;
        wr_entry       = '{last: pick_upd, best: best_upd};
        rd_en          = 1'b0;
        rd_addr        = AW'(diff_wide);

        // result taken downstream
        if (out_valid_reg && m_tready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    target_next = AW'(amount_wide);
                    found_next  = 1'b0;
                    total_next  = '0;
                    count_next  = '0;
                    if (amount_wide > MAX_WIDE)
                    begin
                        // beyond the table: unreachable
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        state_next = ST_ZERO;
                    end
                end
            end

            ST_ZERO:
            begin
                // sum zero needs no coins
                wr_en     = 1'b1;
                wr_addr   = '0;
                wr_entry  = '{last: '0, best: '0};
                s_next    = AW'(1);
                k_next    = '0;
                best_next = UNREACH;
                pick_next = '0;
                if (target_reg == '0)
                begin
                    state_next = ST_LOOK;
                end
                else
                begin
                    state_next = ST_FILL;
                end
            end

            ST_FILL:
            begin
                // slots 0..4 issue reads, slots 1..5 compare the previous read
                best_next = best_upd;
                pick_next = pick_upd;
                if (k_reg < 3'd5)
                begin
                    rd_en     = d_fits;
                    cand_next = d_fits;
                    k_next    = k_reg + 3'd1;
                end
                else
                begin
                    wr_en     = 1'b1;
                    k_next    = '0;
                    best_next = UNREACH;
                    pick_next = '0;
                    if (s_reg == target_reg)
                    begin
                        state_next = ST_LOOK;
                    end
                    else
                    begin
                        s_next = s_reg + AW'(1);
                    end
                end
            end

            ST_LOOK:
            begin
                rd_en      = 1'b1;
                rd_addr    = target_reg;
                state_next = ST_HEAD;
            end

            ST_HEAD:
            begin
                s_next = target_reg;
                if (rd_entry.best == UNREACH)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    found_next = 1'b1;
                    total_next = OUT_W'(rd_entry.best);
                    if (target_reg == '0)
                    begin
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        state_next = ST_WREAD;
                    end
                end
            end

            ST_WREAD:
            begin
                rd_en      = 1'b1;
                rd_addr    = s_reg;
                state_next = ST_WSTEP;
            end

            ST_WSTEP:
            begin
                // follow the last coin of the remaining sum
                if (d_fits)
                begin
                    count_next[rd_entry.last] = count_reg[rd_entry.last] + OUT_W'(1);
                    s_next = AW'(diff_wide);
                    if (diff_wide == '0)
                    begin
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        state_next = ST_WREAD;
                    end
                end
                else
                begin
                    state_next = ST_DONE;
                end
            end

            ST_DONE:
            begin
                // hold until the output register is free
                if (!out_valid_reg || m_tready)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = {3'b000, count_reg[4], count_reg[3], count_reg[2],
                                      count_reg[1], count_reg[0], total_reg, found_reg};
                    state_next     = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            denom_reg     <= DENOM_RESET;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            // indexes past the last denomination are dropped
            if (cfg_valid && (cfg_index < CFG_IDX_W'(NUM_DENOMS)))
            begin
                denom_reg[cfg_index] <= cfg_data;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
        target_reg   <= target_next;
        s_reg        <= s_next;
        k_reg        <= k_next;
        best_reg     <= best_next;
        pick_reg     <= pick_next;
        cand_reg     <= cand_next;
        found_reg    <= found_next;
        total_reg    <= total_next;
        count_reg    <= count_next;
    end

endmodule

/* hdl/mccd_table.sv */
module mccd_table import mccd_pkg::*; #(
    parameter int DEPTH = 1024,
    parameter int AW    = 10
) (
    input  logic          clk,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  entry_t        wr_entry,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr,
    output entry_t        rd_entry
);

    entry_t mem [DEPTH];
    entry_t rd_entry_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_entry;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_entry_reg <= mem[rd_addr];
        end
    end

    assign rd_entry = rd_entry_reg;

endmodule

/* dv/tb_min_coin_change_dp_unit.sv */
`timescale 1ns / 100ps

module tb_min_coin_change_dp_unit;
    import mccd_pkg::*;

    // result layout on m_tdata, lowest bit first: found, total, count_a..count_e
    typedef struct packed {
        logic [2:0]         zero_fill;
        logic [OUT_W-1:0]   count_e;
        logic [OUT_W-1:0]   count_d;
        logic [OUT_W-1:0]   count_c;
        logic [OUT_W-1:0]   count_b;
        logic [OUT_W-1:0]   count_a;
        logic [OUT_W-1:0]   total_coins;
        logic               found;
    } coin_result_t;

    // one result still owed by the block, with the amount that asked for it
    typedef struct {
        logic [DENOM_W-1:0] amount;
        coin_result_t       want;
    } due_change_t;

    // register map; indexes above the last denomination are spare and ignored
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_DENOM_A,
        REG_DENOM_B,
        REG_DENOM_C,
        REG_DENOM_D,
        REG_DENOM_E,
        REG_SPARE_5,
        REG_SPARE_6,
        REG_SPARE_7
    } cfg_reg_e;

    typedef enum bit {
        ROW_WRITE,
        ROW_AMOUNT
    } row_kind_e;

    // directed stimulus row: a register write or an amount, with an optional
    // hand-typed result that replaces the predicted one
    typedef struct {
        row_kind_e          kind;
        cfg_reg_e           reg_sel;
        logic [DENOM_W-1:0] value;
        bit                 typed;
        coin_result_t       want;
    } stim_row_t;

    localparam int NO_WAY          = int'(UNREACH);
    localparam int TABLE_DEPTH     = 1024;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int RANDOM_PHASES   = 5;
    localparam int PHASE_ITEMS     = 16;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               s_tvalid = 1'b0;
    logic               s_tready;
    logic [15:0]        s_tdata = '0;       // amount[9:0], zero fill
    logic               m_tvalid;
    logic               m_tready = 1'b0;
    logic [63:0]        m_tdata;            // found, total_coins, count_a..count_e, zero fill
    logic               cfg_valid = 1'b0;
    logic               cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [DENOM_W-1:0] cfg_data = '0;

    // predictor state: our own copy of the denominations and scratch tables
    denom_arr_t         denom_cfg = DENOM_RESET;
    int                 fewest_tbl [TABLE_DEPTH];
    int                 last_tbl [TABLE_DEPTH];

    due_change_t        change_due_q [$];
    stim_row_t          stim_rows [$];
    int                 mismatches = 0;
    int                 results_seen = 0;
    bit                 no_idle = 1'b0;
    bit                 hold_off_req = 1'b0;

    min_coin_change_dp_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // 10 ns clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // fewest-coins table build, then walk back through the last coins;
    // a denomination only wins a sum with a strictly smaller count
    function automatic coin_result_t solve_min_coins(input logic [DENOM_W-1:0] amount);
        coin_result_t res;
        int           cnt [NUM_DENOMS];
        int           best;
        int           pick;
        int           prev;
        int           sum;
        int           rem;
        int           guard;
        int           d;
        int           k;
        res = '0;
        for (k = 0; k < NUM_DENOMS; k++)
        begin
            cnt[k] = 0;
        end
        fewest_tbl[0] = 0;
        last_tbl[0]   = 0;
        for (sum = 1; sum <= amount; sum++)
        begin
            best = NO_WAY;
            pick = 0;
            for (k = 0; k < NUM_DENOMS; k++)
            begin
                d = denom_cfg[k];
                if (d != 0 && d <= sum)
                begin
                    prev = fewest_tbl[sum - d];
                    if (prev != NO_WAY && prev + 1 < best)
                    begin
                        best = prev + 1;
                        pick = k;
                    end
                end
            end
            fewest_tbl[sum] = best & NO_WAY;
            last_tbl[sum]   = pick;
        end
        // unreachable sums leave every field at zero
        if (fewest_tbl[amount] != NO_WAY)
        begin
            res.found       = 1'b1;
            res.total_coins = OUT_W'(fewest_tbl[amount]);
            rem   = amount;
            guard = 0;
            while (rem > 0 && guard <= TABLE_DEPTH - 1)
            begin
                k = last_tbl[rem];
                d = denom_cfg[k];
                if (d == 0 || d > rem)
                    break;
                cnt[k]++;
                rem -= d;
                guard++;
            end
        end
        res.count_a = OUT_W'(cnt[0]);
        res.count_b = OUT_W'(cnt[1]);
        res.count_c = OUT_W'(cnt[2]);
        res.count_d = OUT_W'(cnt[3]);
        res.count_e = OUT_W'(cnt[4]);
        return res;
    endfunction

    function automatic coin_result_t make_result(input bit found, input int total,
                                                 input int a, input int b, input int c,
                                                 input int d, input int e);
        coin_result_t res;
        res             = '0;
        res.found       = found;
        res.total_coins = OUT_W'(total);
        res.count_a     = OUT_W'(a);
        res.count_b     = OUT_W'(b);
        res.count_c     = OUT_W'(c);
        res.count_d     = OUT_W'(d);
        res.count_e     = OUT_W'(e);
        return res;
    endfunction

    function automatic void add_write(input cfg_reg_e r, input logic [DENOM_W-1:0] v);
        stim_rows.push_back('{ROW_WRITE, r, v, 1'b0, '0});
    endfunction

    function automatic void add_all_denoms(input logic [DENOM_W-1:0] v);
        int k;
        for (k = 0; k < NUM_DENOMS; k++)
        begin
            add_write(cfg_reg_e'(3'(k)), v);
        end
    endfunction

    // amount checked against the predictor
    function automatic void add_amount(input logic [DENOM_W-1:0] v);
        stim_rows.push_back('{ROW_AMOUNT, REG_DENOM_A, v, 1'b0, '0});
    endfunction

    // amount with a result that can be read off directly
    function automatic void add_known(input logic [DENOM_W-1:0] v, input coin_result_t want);
        stim_rows.push_back('{ROW_AMOUNT, REG_DENOM_A, v, 1'b1, want});
    endfunction

    function automatic int idle_cycles();
        return no_idle ? 0 : $urandom_range(0, 18);
    endfunction

    // mostly small denominations so the table has real choices, some
    // disabled ones and an occasional large one
    function automatic logic [DENOM_W-1:0] pick_denom();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0)
            return '0;
        else if (r == 1)
            return DENOM_W'($urandom_range(1, 1023));
        return DENOM_W'($urandom_range(1, 24));
    endfunction

    // large amounts are slow, so only a few of them
    function automatic logic [DENOM_W-1:0] random_amount();
        if ($urandom_range(0, 15) == 0)
            return DENOM_W'($urandom_range(0, 1023));
        return DENOM_W'($urandom_range(0, 80));
    endfunction

    // offer one amount; valid stays high across back-to-back requests
    task automatic send_amount(input logic [DENOM_W-1:0] amt, input bit typed,
                               input coin_result_t typed_res);
        int          gap;
        due_change_t item;
        gap = idle_cycles();
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {6'd0, amt};
        do @(posedge clk); while (!s_tready);
        item.amount = amt;
        item.want   = typed ? typed_res : solve_min_coins(amt);
        change_due_q.push_back(item);
    endtask

    // caller lowers cfg_valid after the last write of a group
    task automatic write_reg(input cfg_reg_e idx, input logic [DENOM_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge clk); while (!cfg_ready);
        if (idx <= REG_DENOM_E)
            denom_cfg[idx] = val;
    endtask

    // stop offering and let every owed result come back; every amount
    // yields a result, so the block is idle once the queue is empty
    task automatic wait_all_results();
        s_tvalid <= 1'b0;
        while (change_due_q.size() != 0) @(posedge clk);
        @(posedge clk);
    endtask

    // result side: random stalls per result, plus one long hold-off on request
    initial
    begin : result_side
        int gap;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (hold_off_req)
            begin
                m_tready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge clk);
                hold_off_req = 1'b0;
            end
            gap = idle_cycles();
            if (gap > 0)
            begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            m_tready <= 1'b1;
            do @(posedge clk); while (!m_tvalid);
        end
    end

    // compare each accepted result with the oldest owed one
    always @(posedge clk)
    begin : result_check
        coin_result_t got;
        due_change_t  head;
        if (rst_n && m_tvalid && m_tready)
        begin
            got = coin_result_t'(m_tdata);
            results_seen++;
            if (change_due_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("result %0d with nothing owed: found=%0d total=%0d",
                             results_seen, got.found, got.total_coins);
            end
            else
            begin
                head = change_due_q.pop_front();
                if (got.found !== head.want.found ||
                    got.total_coins !== head.want.total_coins ||
                    got.count_a !== head.want.count_a ||
                    got.count_b !== head.want.count_b ||
                    got.count_c !== head.want.count_c ||
                    got.count_d !== head.want.count_d ||
                    got.count_e !== head.want.count_e)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                    begin
                        $display("amount %0d: exp found=%0d total=%0d counts=%0d/%0d/%0d/%0d/%0d",
                                 head.amount, head.want.found, head.want.total_coins,
                                 head.want.count_a, head.want.count_b, head.want.count_c,
                                 head.want.count_d, head.want.count_e);
                        $display("amount %0d: got found=%0d total=%0d counts=%0d/%0d/%0d/%0d/%0d",
                                 head.amount, got.found, got.total_coins, got.count_a,
                                 got.count_b, got.count_c, got.count_d, got.count_e);
                    end
                end
            end
        end
    end

    // stimulus: directed table first, then random phases
    initial
    begin : request_side
        bit cfg_open;
        int phase;
        int n;
        int k;

        // reset denominations 1,3,7,15,31
        add_known(10'd0,   make_result(1, 0, 0, 0, 0, 0, 0));
        add_known(10'd1,   make_result(1, 1, 1, 0, 0, 0, 0));
        add_known(10'd31,  make_result(1, 1, 0, 0, 0, 0, 1));
        add_amount(10'h2AA);
        add_amount(10'h155);
        add_amount(10'h3FF);
        // writes to spare indexes must not disturb the denominations
        add_write(REG_SPARE_5, 10'h3FF);
        add_write(REG_SPARE_6, 10'd0);
        add_write(REG_SPARE_7, 10'd2);
        add_known(10'd2,   make_result(1, 2, 2, 0, 0, 0, 0));
        // disabled denominations, only even coins left
        add_write(REG_DENOM_A, 10'd0);
        add_write(REG_DENOM_B, 10'd2);
        add_write(REG_DENOM_C, 10'd4);
        add_write(REG_DENOM_D, 10'd0);
        add_write(REG_DENOM_E, 10'd0);
        add_known(10'd7,   '0);
        add_known(10'd1,   '0);
        add_amount(10'd10);
        add_known(10'd0,   make_result(1, 0, 0, 0, 0, 0, 0));
        // all equal: the lowest index takes every coin
        add_all_denoms(10'd5);
        add_known(10'd10,  make_result(1, 2, 2, 0, 0, 0, 0));
        add_known(10'd3,   '0);
        // largest coin values
        add_all_denoms(10'h3FF);
        add_known(10'h3FF, make_result(1, 1, 1, 0, 0, 0, 0));
        add_known(10'h3FE, '0);
        // single unit coin: largest total and count
        add_all_denoms(10'd0);
        add_write(REG_DENOM_A, 10'd1);
        add_known(10'h3FF, make_result(1, 1023, 1023, 0, 0, 0, 0));
        // every coin disabled: only zero can be made
        add_all_denoms(10'd0);
        add_known(10'd0,   make_result(1, 0, 0, 0, 0, 0, 0));
        add_known(10'd5,   '0);
        // mixed large and small coins
        add_write(REG_DENOM_A, 10'h3FF);
        add_write(REG_DENOM_B, 10'd1);
        add_write(REG_DENOM_E, 10'd512);
        add_known(10'h3FF, make_result(1, 1, 1, 0, 0, 0, 0));
        add_amount(10'h3FE);

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // walk the table; register writes only once the block has drained
        cfg_open = 1'b0;
        foreach (stim_rows[i])
        begin
            if (stim_rows[i].kind == ROW_WRITE)
            begin
                if (!cfg_open)
                begin
                    wait_all_results();
                    cfg_open = 1'b1;
                end
                write_reg(stim_rows[i].reg_sel, stim_rows[i].value);
            end
            else
            begin
                if (cfg_open)
                begin
                    cfg_valid <= 1'b0;
                    cfg_open = 1'b0;
                end
                send_amount(stim_rows[i].value, stim_rows[i].typed, stim_rows[i].want);
            end
        end

        // random phases, each with a fresh set of denominations
        for (phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            wait_all_results();
            for (k = 0; k < NUM_DENOMS; k++)
            begin
                write_reg(cfg_reg_e'(3'(k)), pick_denom());
            end
            if ($urandom_range(0, 1) == 1)
                write_reg(cfg_reg_e'(3'($urandom_range(5, 7))), DENOM_W'($urandom));
            cfg_valid <= 1'b0;
            // one phase runs with no idling on either side
            no_idle = (phase == 3);
            // long hold-off on the result side while small amounts keep coming
            if (phase == 1)
                hold_off_req = 1'b1;
            for (n = 0; n < PHASE_ITEMS; n++)
            begin
                // pause the requests until everything owed has come back
                if (phase == 2 && n == PHASE_ITEMS / 2)
                    wait_all_results();
                if (phase == 1 && n < 12)
                    send_amount(DENOM_W'($urandom_range(0, 10)), 1'b0, '0);
                else
                    send_amount(random_amount(), 1'b0, '0);
            end
        end

        // drain, then a short idle tail to catch stray results
        s_tvalid <= 1'b0;
        while (change_due_q.size() != 0) @(posedge clk);
        repeat (50) @(posedge clk);
        if (mismatches == 0 && change_due_q.size() == 0)
            $display("tb_min_coin_change_dp_unit: clean");
        else
            $display("tb_min_coin_change_dp_unit: errors");
        $finish;
    end

    // run limit, several times the slowest legal run
    initial
    begin
        #60_000_000;
        $display("tb_min_coin_change_dp_unit: errors");
        $finish;
    end

endmodule

/* min_coin_change_dp_unit.f */
hdl/mccd_pkg.sv
hdl/mccd_table.sv
hdl/min_coin_change_dp_unit.sv
dv/tb_min_coin_change_dp_unit.sv
